// ===== design/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and codes of the union-find store with rollback: request and
// response words, command and status codes, default node count.
// ----------------------------------------------------------------------------
package ufr_pkg;

   localparam int NODE_COUNT_DEF = 1024;

   localparam int CMD_W   = 2;
   localparam int NODE_W  = 10;
   localparam int SIZE_W  = 11;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_UNION = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNDO  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_SAME  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_word_type;

   typedef struct packed {
      logic [SIZE_W-1:0] set_size;
      logic [STAT_W-1:0] status;
   } rsp_word_type;

endpackage

// ===== design/ufr_ram.sv =====
// ----------------------------------------------------------------------------
// ufr_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ufr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/union_find_with_rollback_unit.sv =====
// ----------------------------------------------------------------------------
// union_find_with_rollback_unit
// Disjoint-set store with union by rank, no path compression and an undo
// stack. Commands: union two nodes, undo the last union, query a set size.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  request  start, busy, req_word      word taken when start & !busy
//  response rsp_valid, rsp_word        one-cycle strobe, cannot be held off
//
//  After reset a clearing pass loads the node RAM; busy stays high meanwhile.
//  Each word then runs alone through the sequencer, which does one node RAM
//  access per cycle: a query walks node a to its root, a union walks both and
//  links their roots, an undo restores both roots. Depth below a root is at
//  most log2(NODE_COUNT). Rejected words answer from idle. The response strobe
//  comes in the first cycle with busy low, and the next word may be taken then.
// ----------------------------------------------------------------------------
module union_find_with_rollback_unit #(
   parameter int NODE_COUNT = ufr_pkg::NODE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ufr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ufr_pkg::rsp_word_type rsp_word
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int RW = $clog2($clog2(NODE_COUNT) + 1);
   localparam int SW = $clog2(NODE_COUNT + 1);
   localparam int NW = IW + RW + SW;
   localparam int KW = IW + IW + 1;
   localparam logic [31:0]   NODE_LIMIT = 32'(NODE_COUNT);
   localparam logic [IW-1:0] LAST_IDX   = IW'(NODE_COUNT - 1);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_WALK_A    = 4'd2;
   localparam logic [3:0] S_WALK_B    = 4'd3;
   localparam logic [3:0] S_LINK_LOW  = 4'd4;
   localparam logic [3:0] S_WRITE_TOP = 4'd5;
   localparam logic [3:0] S_UNDO_KID  = 4'd6;
   localparam logic [3:0] S_UNDO_PAR  = 4'd7;
   localparam logic [3:0] S_UNDO_FIX  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW-1:0] count_ff, count_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] b_idx_ff, b_idx_in;
   logic [IW-1:0] ra_idx_ff, ra_idx_in;
   logic [RW-1:0] ra_rank_ff, ra_rank_in;
   logic [SW-1:0] ra_size_ff, ra_size_in;
   logic [IW-1:0] top_idx_ff, top_idx_in;
   logic [RW-1:0] top_rank_ff, top_rank_in;
   logic [SW-1:0] top_size_ff, top_size_in;
   logic [IW-1:0] low_idx_ff, low_idx_in;
   logic [RW-1:0] low_rank_ff, low_rank_in;
   logic [SW-1:0] low_size_ff, low_size_in;
   logic          grew_ff, grew_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ufr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic          node_we;
   logic [IW-1:0] node_waddr;
   logic [NW-1:0] node_wdata;
   logic [IW-1:0] node_raddr;
   logic [NW-1:0] node_rdata;
   logic [IW-1:0] rd_parent;
   logic [RW-1:0] rd_rank;
   logic [SW-1:0] rd_size;
   logic          rd_root;

   logic          stk_we;
   logic [KW-1:0] stk_wdata;
   logic [IW-1:0] stk_raddr;
   logic [KW-1:0] stk_rdata;

   logic          a_bad, b_bad;

   ufr_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   ufr_ram #(.WIDTH(KW), .DEPTH(NODE_COUNT)) u_undo_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (count_ff),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign rd_parent = node_rdata[NW-1 -: IW];
   assign rd_rank   = node_rdata[SW +: RW];
   assign rd_size   = node_rdata[SW-1:0];
   assign rd_root   = (rd_parent == cur_ff);

   assign a_bad = (32'(req_word.node_a) >= NODE_LIMIT);
   assign b_bad = (32'(req_word.node_b) >= NODE_LIMIT);

   assign stk_raddr = count_ff - 1'b1;
   assign stk_wdata = {top_idx_ff, low_idx_ff, grew_ff};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      b_idx_in     = b_idx_ff;
      ra_idx_in    = ra_idx_ff;
      ra_rank_in   = ra_rank_ff;
      ra_size_in   = ra_size_ff;
      top_idx_in   = top_idx_ff;
      top_rank_in  = top_rank_ff;
      top_size_in  = top_size_ff;
      low_idx_in   = low_idx_ff;
      low_rank_in  = low_rank_ff;
      low_size_in  = low_size_ff;
      grew_in      = grew_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      node_we      = 1'b0;
      node_waddr   = low_idx_ff;
      node_wdata   = {top_idx_ff, low_rank_ff, low_size_ff};
      node_raddr   = cur_ff;
      stk_we       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = {clr_ff, RW'(0), SW'(1)};
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            node_raddr = IW'(req_word.node_a);
            if (start) begin
               cmd_in   = req_word.command;
               cur_in   = IW'(req_word.node_a);
               b_idx_in = IW'(req_word.node_b);
               rsp_word_in.set_size = '0;
               rsp_word_in.status   = ufr_pkg::ST_OK;
               case (req_word.command)
                  ufr_pkg::CMD_UNION: begin
                     if (a_bad || b_bad) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_WALK_A;
                     end
                  end
                  ufr_pkg::CMD_QUERY: begin
                     if (a_bad) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_WALK_A;
                     end
                  end
                  ufr_pkg::CMD_UNDO: begin
                     if (count_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_word_in.status = ufr_pkg::ST_EMPTY;
                     end else begin
                        // pop now; the top entry is read at the old count - 1
                        count_in = count_ff - 1'b1;
                        state_in = S_UNDO_KID;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_WALK_A: begin
            if (rd_root) begin
               if (cmd_ff == ufr_pkg::CMD_QUERY) begin
                  rsp_valid_in         = 1'b1;
                  rsp_word_in.set_size = ufr_pkg::SIZE_W'(rd_size);
                  rsp_word_in.status   = ufr_pkg::ST_OK;
                  state_in             = S_IDLE;
               end else begin
                  ra_idx_in  = cur_ff;
                  ra_rank_in = rd_rank;
                  ra_size_in = rd_size;
                  node_raddr = b_idx_ff;
                  cur_in     = b_idx_ff;
                  state_in   = S_WALK_B;
               end
            end else begin
               node_raddr = rd_parent;
               cur_in     = rd_parent;
            end
         end
         S_WALK_B: begin
            if (rd_root) begin
               if (cur_ff == ra_idx_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_word_in.set_size = '0;
                  rsp_word_in.status   = ufr_pkg::ST_SAME;
                  state_in             = S_IDLE;
               end else if (rd_rank > ra_rank_ff) begin
                  top_idx_in  = cur_ff;
                  top_rank_in = rd_rank;
                  top_size_in = rd_size;
                  low_idx_in  = ra_idx_ff;
                  low_rank_in = ra_rank_ff;
                  low_size_in = ra_size_ff;
                  grew_in     = 1'b0;
                  state_in    = S_LINK_LOW;
               end else begin
                  top_idx_in  = ra_idx_ff;
                  top_rank_in = ra_rank_ff;
                  top_size_in = ra_size_ff;
                  low_idx_in  = cur_ff;
                  low_rank_in = rd_rank;
                  low_size_in = rd_size;
                  grew_in     = (rd_rank == ra_rank_ff);
                  state_in    = S_LINK_LOW;
               end
            end else begin
               node_raddr = rd_parent;
               cur_in     = rd_parent;
            end
         end
         S_LINK_LOW: begin
            // hang the lower root under the top root and push the record
            node_we     = 1'b1;
            node_waddr  = low_idx_ff;
            node_wdata  = {top_idx_ff, low_rank_ff, low_size_ff};
            stk_we      = 1'b1;
            count_in    = count_ff + 1'b1;
            top_rank_in = top_rank_ff + RW'(grew_ff);
            top_size_in = top_size_ff + low_size_ff;
            state_in    = S_WRITE_TOP;
         end
         S_WRITE_TOP: begin
            node_we              = 1'b1;
            node_waddr           = top_idx_ff;
            node_wdata           = {top_idx_ff, top_rank_ff, top_size_ff};
            rsp_valid_in         = 1'b1;
            rsp_word_in.status   = ufr_pkg::ST_OK;
            rsp_word_in.set_size = (cmd_ff == ufr_pkg::CMD_UNION) ?
                                   ufr_pkg::SIZE_W'(top_size_ff) : '0;
            state_in             = S_IDLE;
         end
         S_UNDO_KID: begin
            top_idx_in = stk_rdata[KW-1 -: IW];
            low_idx_in = stk_rdata[IW:1];
            grew_in    = stk_rdata[0];
            node_raddr = stk_rdata[IW:1];
            state_in   = S_UNDO_PAR;
         end
         S_UNDO_PAR: begin
            low_rank_in = rd_rank;
            low_size_in = rd_size;
            node_raddr  = top_idx_ff;
            state_in    = S_UNDO_FIX;
         end
         S_UNDO_FIX: begin
            // relink the child to itself, then shrink the parent
            node_we     = 1'b1;
            node_waddr  = low_idx_ff;
            node_wdata  = {low_idx_ff, low_rank_ff, low_size_ff};
            top_rank_in = rd_rank - RW'(grew_ff);
            top_size_in = rd_size - low_size_ff;
            state_in    = S_WRITE_TOP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      b_idx_ff    <= b_idx_in;
      ra_idx_ff   <= ra_idx_in;
      ra_rank_ff  <= ra_rank_in;
      ra_size_ff  <= ra_size_in;
      top_idx_ff  <= top_idx_in;
      top_rank_ff <= top_rank_in;
      top_size_ff <= top_size_in;
      low_idx_ff  <= low_idx_in;
      low_rank_ff <= low_rank_in;
      low_size_ff <= low_size_in;
      grew_ff     <= grew_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response strobe outside idle");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK_LOW) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("union did not push the undo stack");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.status == ufr_pkg::ST_EMPTY) |-> (count_ff == '0))
      else $error("empty-stack status with entries held");

   a_undo_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_word.command == ufr_pkg::CMD_UNDO &&
       count_ff != '0) |=> (state_ff == S_UNDO_KID && count_ff == $past(count_ff) - 1'b1))
      else $error("undo did not pop the stack");

endmodule
